/* rtl/float32_arith_compare_unit_macros.svh */
// ----------------------------------------------------------------------------
// float32_arith_compare_unit_macros
// Assertion macros shared by the float32 arithmetic/compare unit.
// ----------------------------------------------------------------------------
`ifndef FLOAT32_ARITH_COMPARE_UNIT_MACROS_SVH
`define FLOAT32_ARITH_COMPARE_UNIT_MACROS_SVH

// same-cycle implication
`define FPACU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpacu check failed");

// next-cycle implication
`define FPACU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpacu check failed");

`endif

/* rtl/fpacu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpacu_pkg
// Types, codes and helpers of the float32 arithmetic/compare unit.
// ----------------------------------------------------------------------------
package fpacu_pkg;

  localparam int unsigned DivCells = 27;

  localparam logic [31:0] SignBit    = 32'h8000_0000;
  localparam logic [31:0] ExpInf     = 32'h7F80_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [31:0] DefaultNan = 32'h7FC0_0000;
  localparam logic [31:0] OneBits    = 32'h3F80_0000;

  typedef enum logic [3:0] {
    OP_EQ  = 4'd0,
    OP_NE  = 4'd1,
    OP_LT  = 4'd2,
    OP_LE  = 4'd3,
    OP_GT  = 4'd4,
    OP_GE  = 4'd5,
    OP_ADD = 4'd6,
    OP_SUB = 4'd7,
    OP_MUL = 4'd8,
    OP_DIV = 4'd9,
    OP_OR  = 4'd10,
    OP_AND = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_ADD,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  typedef logic signed [11:0] exp_t;

  typedef struct packed {
    logic [31:0] left_operand;
    logic [31:0] right_operand;
    logic [3:0]  operation;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        divide_by_zero;
    logic        unknown_operation;
  } out_beat_t;

  // unpacked operands, significands normalized to bit 23
  typedef struct packed {
    op_e         op;
    logic        sa;
    logic        sb;
    exp_t        ea;
    exp_t        eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        special;
    logic [31:0] fixed;
    logic        dz;
    logic        unk;
  } unp_t;

  // item state carried down the divider cells
  typedef struct packed {
    kind_e       kind;
    logic        sign;
    exp_t        expo;
    logic [47:0] wide;
    logic [24:0] rem;
    logic [23:0] dvsr;
    logic [31:0] fixed;
    logic        dz;
    logic        unk;
  } pipe_t;

  function automatic logic [4:0] lzc24(input logic [23:0] x);
    logic [4:0] cnt;
    cnt = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) cnt = 5'(23 - i);
    end
    return cnt;
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] x);
    logic [4:0] cnt;
    cnt = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (x[i]) cnt = 5'(27 - i);
    end
    return cnt;
  endfunction

endpackage

/* rtl/fpacu_unpack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpacu_unpack
// Input stage: classifies operands, resolves compares, logic ops and IEEE
// special cases, and normalizes finite significands.
// ----------------------------------------------------------------------------
module fpacu_unpack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  fpacu_pkg::in_beat_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output fpacu_pkg::unp_t     data_o
);

  logic            v_q;
  fpacu_pkg::unp_t d_q, d_d;

  function automatic logic [35:0] norm_op(input logic [31:0] x);
    logic [23:0]     sig;
    fpacu_pkg::exp_t e0;
    logic [4:0]      l;
    sig = (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
    e0  = (x[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, x[30:23]}) - 12'sd150;
    l   = fpacu_pkg::lzc24(sig);
    return {e0 - $signed({7'b0, l}), sig << l};
  endfunction

  logic [31:0]    a, b_raw, b, nan_pick, ka, kb;
  logic           a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, any_nan;
  logic           eq, lt, gt, sgn_p;
  logic [35:0]    na, nb;
  fpacu_pkg::op_e op;

  always_comb begin
    a      = data_i.left_operand;
    b_raw  = data_i.right_operand;
    op     = fpacu_pkg::op_e'(data_i.operation);
    a_nan  = a[30:0] > 31'h7F80_0000;
    b_nan  = b_raw[30:0] > 31'h7F80_0000;
    a_inf  = a[30:0] == 31'h7F80_0000;
    b_inf  = b_raw[30:0] == 31'h7F80_0000;
    a_zero = a[30:0] == 31'd0;
    b_zero = b_raw[30:0] == 31'd0;
    any_nan = a_nan || b_nan;
    b = (op == fpacu_pkg::OP_SUB && !b_nan) ? {~b_raw[31], b_raw[30:0]} : b_raw;
    nan_pick = a_nan ? (a | fpacu_pkg::QuietBit) : (b_raw | fpacu_pkg::QuietBit);
    ka = a_zero ? fpacu_pkg::SignBit : (a[31] ? ~a : (a | fpacu_pkg::SignBit));
    kb = b_zero ? fpacu_pkg::SignBit : (b_raw[31] ? ~b_raw : (b_raw | fpacu_pkg::SignBit));
    eq = !any_nan && (ka == kb);
    lt = !any_nan && (ka < kb);
    gt = !any_nan && (kb < ka);
    sgn_p = a[31] ^ b_raw[31];
    na = norm_op(a);
    nb = norm_op(b);

    d_d.op      = op;
    d_d.sa      = a[31];
    d_d.sb      = b[31];
    d_d.ea      = na[35:24];
    d_d.eb      = nb[35:24];
    d_d.ma      = na[23:0];
    d_d.mb      = nb[23:0];
    d_d.special = 1'b1;
    d_d.fixed   = 32'd0;
    d_d.dz      = 1'b0;
    d_d.unk     = 1'b0;

    case (op)
      fpacu_pkg::OP_EQ: d_d.fixed = eq ? fpacu_pkg::OneBits : 32'd0;
      fpacu_pkg::OP_NE: d_d.fixed = !eq ? fpacu_pkg::OneBits : 32'd0;
      fpacu_pkg::OP_LT: d_d.fixed = lt ? fpacu_pkg::OneBits : 32'd0;
      fpacu_pkg::OP_LE: d_d.fixed = (lt || eq) ? fpacu_pkg::OneBits : 32'd0;
      fpacu_pkg::OP_GT: d_d.fixed = gt ? fpacu_pkg::OneBits : 32'd0;
      fpacu_pkg::OP_GE: d_d.fixed = (gt || eq) ? fpacu_pkg::OneBits : 32'd0;
      fpacu_pkg::OP_OR: d_d.fixed = (!a_zero || !b_zero) ? fpacu_pkg::OneBits : 32'd0;
      fpacu_pkg::OP_AND: d_d.fixed = (!a_zero && !b_zero) ? fpacu_pkg::OneBits : 32'd0;
      fpacu_pkg::OP_ADD, fpacu_pkg::OP_SUB: begin
        if (any_nan) d_d.fixed = nan_pick;
        else if (a_inf) d_d.fixed = (b_inf && (a[31] != b[31])) ? fpacu_pkg::DefaultNan : a;
        else if (b_inf) d_d.fixed = b;
        else if (a_zero && b_zero) d_d.fixed = {a[31] & b[31], 31'd0};
        else if (a_zero) d_d.fixed = b;
        else if (b_zero) d_d.fixed = a;
        else d_d.special = 1'b0;
      end
      fpacu_pkg::OP_MUL: begin
        if (any_nan) d_d.fixed = nan_pick;
        else if (a_inf || b_inf) begin
          d_d.fixed = (a_zero || b_zero) ? fpacu_pkg::DefaultNan
                                         : ({sgn_p, 31'd0} | fpacu_pkg::ExpInf);
        end else if (a_zero || b_zero) d_d.fixed = {sgn_p, 31'd0};
        else d_d.special = 1'b0;
      end
      fpacu_pkg::OP_DIV: begin
        d_d.dz = b_zero;
        if (any_nan) d_d.fixed = nan_pick;
        else if (a_inf) begin
          d_d.fixed = b_inf ? fpacu_pkg::DefaultNan : ({sgn_p, 31'd0} | fpacu_pkg::ExpInf);
        end else if (b_inf) d_d.fixed = {sgn_p, 31'd0};
        else if (b_zero) begin
          d_d.fixed = a_zero ? fpacu_pkg::DefaultNan : ({sgn_p, 31'd0} | fpacu_pkg::ExpInf);
        end else if (a_zero) d_d.fixed = {sgn_p, 31'd0};
        else d_d.special = 1'b0;
      end
      default: d_d.unk = 1'b1;
    endcase
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

/* rtl/fpacu_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpacu_div_cell
// One cell of the divider row: produces one quotient bit per beat and hands
// the partial remainder on; other operations pass through.
// ----------------------------------------------------------------------------
module fpacu_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  fpacu_pkg::pipe_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output fpacu_pkg::pipe_t data_o
);

  logic             v_q;
  fpacu_pkg::pipe_t d_q, d_d;
  logic             ge;
  logic [24:0]      r;

  always_comb begin
    d_d = data_i;
    ge  = data_i.rem >= {1'b0, data_i.dvsr};
    r   = ge ? (data_i.rem - {1'b0, data_i.dvsr}) : data_i.rem;
    if (data_i.kind == fpacu_pkg::KIND_DIV) begin
      d_d.rem  = {r[23:0], 1'b0};
      d_d.wide = {data_i.wide[46:0], ge};
    end
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

/* rtl/fpacu_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpacu_round
// Two stages: normalize the raw sum, product or quotient, then round to
// nearest-even with subnormal and overflow handling. Holds the output beat.
// ----------------------------------------------------------------------------
module fpacu_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  fpacu_pkg::pipe_t     data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output fpacu_pkg::out_beat_t data_o
);

  typedef struct packed {
    logic            is_fixed;
    logic [31:0]     fixed;
    logic            sign;
    fpacu_pkg::exp_t e;
    logic [27:0]     m;
    logic            dz;
    logic            unk;
  } nrm_t;

  logic                 v1_q, v2_q, rdy1, rdy2;
  nrm_t                 n_q, n_d;
  fpacu_pkg::out_beat_t o_q, o_d;

  logic [27:0] sum;
  logic [4:0]  l;
  logic [47:0] p;
  logic [26:0] q;
  logic        st;

  always_comb begin
    sum = data_i.wide[27:0];
    l   = fpacu_pkg::lzc28(sum);
    p   = data_i.wide;
    q   = data_i.wide[26:0];
    st  = data_i.rem != 25'd0;
    n_d.is_fixed = 1'b0;
    n_d.fixed    = data_i.fixed;
    n_d.sign     = data_i.sign;
    n_d.e        = data_i.expo;
    n_d.m        = 28'd0;
    n_d.dz       = data_i.dz;
    n_d.unk      = data_i.unk;
    case (data_i.kind)
      fpacu_pkg::KIND_ADD: begin
        if (sum == 28'd0) begin
          n_d.is_fixed = 1'b1;
          n_d.fixed    = 32'd0;
        end else begin
          n_d.m = sum << l;
          n_d.e = data_i.expo - $signed({7'b0, l});
        end
      end
      fpacu_pkg::KIND_MUL: begin
        if (p[47]) begin
          n_d.m = {p[47:21], p[20] | (|p[19:0])};
          n_d.e = data_i.expo + 12'sd20;
        end else begin
          n_d.m = {p[46:20], |p[19:0]};
          n_d.e = data_i.expo + 12'sd19;
        end
      end
      fpacu_pkg::KIND_DIV: begin
        if (q[26]) begin
          n_d.m = {q, st};
          n_d.e = data_i.expo - 12'sd27;
        end else begin
          n_d.m = {q[25:0], 1'b0, st};
          n_d.e = data_i.expo - 12'sd28;
        end
      end
      default: n_d.is_fixed = 1'b1;
    endcase
  end

  fpacu_pkg::exp_t be, base, sh;
  logic [27:0]     mm;
  logic            inc;
  logic [24:0]     q25;
  logic [35:0]     tot;

  always_comb begin
    be = n_q.e + 12'sd154;
    sh = 12'sd1 - be;
    if (be > 12'sd0) begin
      mm   = n_q.m;
      base = be - 12'sd1;
    end else begin
      base = 12'sd0;
      if (sh >= 12'sd28) begin
        mm = {27'd0, |n_q.m};
      end else begin
        mm = (n_q.m >> sh[4:0]) |
             {27'd0, |(n_q.m & ((28'd1 << sh[4:0]) - 28'd1))};
      end
    end
    inc = mm[3] & ((|mm[2:0]) | mm[4]);
    q25 = {1'b0, mm[27:4]} + {24'd0, inc};
    tot = {1'b0, base, 23'd0} + {11'd0, q25};
    o_d.divide_by_zero    = n_q.dz;
    o_d.unknown_operation = n_q.unk;
    if (n_q.is_fixed) begin
      o_d.result_bits = n_q.fixed;
    end else if (tot >= 36'h0_7F80_0000) begin
      o_d.result_bits = {n_q.sign, 31'd0} | fpacu_pkg::ExpInf;
    end else begin
      o_d.result_bits = {n_q.sign, tot[30:0]};
    end
  end

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) n_q <= n_d;
    if (rdy2) o_q <= o_d;
  end

  assign valid_o = v2_q;
  assign data_o  = o_q;

endmodule

/* rtl/float32_arith_compare_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_arith_compare_unit
// Path from input beat to output beat: unpack, operand prep, 27 divider
//   cells at one quotient bit each, normalize, round.
// Throughput: one beat per cycle unless stalled; bubbles collapse on stall.
// Reset clears stage valid bits only; no other state.
// ----------------------------------------------------------------------------
`include "float32_arith_compare_unit_macros.svh"

module float32_arith_compare_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fpacu_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fpacu_pkg::out_beat_t out_data_o
);

  logic            unp_v, unp_r;
  fpacu_pkg::unp_t unp_d;

  fpacu_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (unp_v),
    .ready_i (unp_r),
    .data_o  (unp_d)
  );

  // operand prep: product, aligned sum, divider seed
  logic             prep_v_q;
  fpacu_pkg::pipe_t prep_q, prep_d;
  logic             cell_v [fpacu_pkg::DivCells+1];
  logic             cell_r [fpacu_pkg::DivCells+1];
  fpacu_pkg::pipe_t cell_d [fpacu_pkg::DivCells+1];

  logic            swap, big_s;
  fpacu_pkg::exp_t big_e, sm_e, d;
  logic [23:0]     big_m, sm_m;
  logic [26:0]     x, al;

  always_comb begin
    swap  = (unp_d.eb > unp_d.ea) || ((unp_d.eb == unp_d.ea) && (unp_d.mb > unp_d.ma));
    big_s = swap ? unp_d.sb : unp_d.sa;
    big_e = swap ? unp_d.eb : unp_d.ea;
    big_m = swap ? unp_d.mb : unp_d.ma;
    sm_e  = swap ? unp_d.ea : unp_d.eb;
    sm_m  = swap ? unp_d.ma : unp_d.mb;
    d     = big_e - sm_e;
    x     = {sm_m, 3'b0};
    if (d >= 12'sd27) begin
      al = 27'd1;
    end else begin
      al = (x >> d[4:0]) | {26'd0, |(x & ((27'd1 << d[4:0]) - 27'd1))};
    end

    prep_d.kind  = fpacu_pkg::KIND_FIXED;
    prep_d.sign  = unp_d.sa ^ unp_d.sb;
    prep_d.expo  = unp_d.ea + unp_d.eb;
    prep_d.wide  = 48'd0;
    prep_d.rem   = {1'b0, unp_d.ma};
    prep_d.dvsr  = unp_d.mb;
    prep_d.fixed = unp_d.fixed;
    prep_d.dz    = unp_d.dz;
    prep_d.unk   = unp_d.unk;
    if (!unp_d.special) begin
      case (unp_d.op)
        fpacu_pkg::OP_ADD, fpacu_pkg::OP_SUB: begin
          prep_d.kind = fpacu_pkg::KIND_ADD;
          prep_d.sign = big_s;
          prep_d.expo = big_e - 12'sd3;
          prep_d.wide = (unp_d.sa == unp_d.sb)
                      ? {20'd0, {1'b0, big_m, 3'b0} + {1'b0, al}}
                      : {20'd0, {1'b0, big_m, 3'b0} - {1'b0, al}};
        end
        fpacu_pkg::OP_MUL: begin
          prep_d.kind = fpacu_pkg::KIND_MUL;
          prep_d.wide = unp_d.ma * unp_d.mb;
        end
        fpacu_pkg::OP_DIV: begin
          prep_d.kind = fpacu_pkg::KIND_DIV;
          prep_d.expo = unp_d.ea - unp_d.eb;
        end
        default: prep_d.kind = fpacu_pkg::KIND_FIXED;
      endcase
    end
  end

  assign unp_r = !prep_v_q || cell_r[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (unp_r) begin
      prep_v_q <= unp_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (unp_r) begin
      prep_q <= prep_d;
    end
  end

  assign cell_v[0] = prep_v_q;
  assign cell_d[0] = prep_q;

  for (genvar k = 0; k < fpacu_pkg::DivCells; k++) begin : g_cell
    fpacu_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_v[k]),
      .ready_o (cell_r[k]),
      .data_i  (cell_d[k]),
      .valid_o (cell_v[k+1]),
      .ready_i (cell_r[k+1]),
      .data_o  (cell_d[k+1])
    );
  end

  fpacu_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cell_v[fpacu_pkg::DivCells]),
    .ready_o (cell_r[fpacu_pkg::DivCells]),
    .data_i  (cell_d[fpacu_pkg::DivCells]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  `FPACU_ASSERT_IMP(a_unk_zero, out_valid_o && out_data_o.unknown_operation, out_data_o.result_bits == 32'd0 && !out_data_o.divide_by_zero)
  `FPACU_ASSERT_IMP(a_full_only_on_stall, !in_ready_o, out_valid_o && !out_ready_i)
  `FPACU_ASSERT_NXT(a_accept_enters, in_valid_i && in_ready_o, unp_v)

endmodule
